[src/osas_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the obstacle summed-area stream core.
package osas_pkg;

    localparam int SUM_W  = 21;
    localparam int ROW_W  = 10;
    localparam int COL_W  = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [7:0] NEWLINE_BYTE = 8'd10;

    // Register map of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OBST_CHAR  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_CHAR = 2'd3;

    localparam logic [COL_W-1:0] RST_MAP_WIDTH  = 11'd1;
    localparam logic [COL_W-1:0] RST_MAP_HEIGHT = 11'd1;
    localparam logic [7:0]       RST_OBST_CHAR  = 8'd111;
    localparam logic [7:0]       RST_EMPTY_CHAR = 8'd46;

    typedef enum logic [1:0] {
        KIND_CELL     = 2'd0,
        KIND_ROW_END  = 2'd1,
        KIND_BAD_CHAR = 2'd2,
        KIND_BAD_LEN  = 2'd3
    } kind_t;

endpackage

[src/obstacle_summed_area_stream_core.sv]
`timescale 1ns / 1ps
// Streaming summed-area (integral image) counter of obstacle cells in a character map.
//
// Usage: map bytes arrive on the input channel (in_valid, in_stall, map_byte), row by
// row, each row closed by a newline byte. Every accepted beat yields exactly one result
// beat on the output channel (out_valid, out_stall and the result fields): a cell count,
// a row end, or an error report. Once an error is reported the block stays in error and
// answers every further beat with an error kind until reset.
// An accepted beat passes through the working stage and then the output register, and
// a stall holds it where it is. The block takes one beat per cycle while the output is
// not stalled: the line buffer of previous-row sums is read at acceptance and written as
// the beat leaves the working stage, always at two different columns, so no interlock is
// ever needed. A row end reports the sum of the last cell of its row, which is kept in
// a register, so newlines do not touch the line buffer.
// When the receiver stalls, the output register holds its beat, the working stage holds
// one more, and in_stall rises so that further input waits; nothing is lost.
// Reset clears the control state and loads the register defaults (width and height 1,
// obstacle 'o', empty '.'). The line buffer is not cleared and needs no clearing pass:
// row 0 ignores what it reads; each later row reads only entries the row above wrote.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are always taken.
module obstacle_summed_area_stream_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Map byte input
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         map_byte,
    // Result output
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [osas_pkg::SUM_W-1:0]         rect_count,
    output logic [osas_pkg::ROW_W-1:0]         cell_row,
    output logic [osas_pkg::COL_W-1:0]         cell_col,
    output osas_pkg::kind_t                    kind,
    output logic                               map_done,
    // Configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [osas_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [osas_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import osas_pkg::*;

    // Line buffer address width and current-row register width follow the maxima.
    localparam int AW  = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // Everything the second stage needs to finish one beat.
    typedef struct packed {
        kind_t            kind;
        logic             is_cell;     // cell count that reads and writes the line buffer
        logic             zero_count;  // error beats report a count of zero
        logic             first_row;   // row 0 adds nothing from above
        logic             done;
        logic [RW-1:0]    row;
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] row_obst;    // running obstacle count including this cell
    } stage_t;

    // Configuration registers
    logic [COL_W-1:0] map_width_reg;
    logic [COL_W-1:0] map_height_reg;
    logic [7:0]       obst_char_reg;
    logic [7:0]       empty_char_reg;

    // Control state
    logic [COL_W-1:0] row_obst_reg, row_obst_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic             err_reg, err_next;

    // Pipeline
    logic             s1_valid_reg;
    stage_t           s1_reg, s1_next;
    logic [SUM_W-1:0] rd_sum_reg;
    logic [SUM_W-1:0] last_sum_reg;
    logic [SUM_W-1:0] prev_sums_reg [MAX_WIDTH];

    logic             out_valid_reg;
    logic [SUM_W-1:0] out_count_reg;
    logic [RW-1:0]    out_row_reg;
    logic [COL_W-1:0] out_col_reg;
    kind_t            out_kind_reg;
    logic             out_done_reg;

    logic             out_free;
    logic             s1_adv;
    logic             accept;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    logic [SUM_W-1:0] s1_sum;
    logic [SUM_W-1:0] s1_count;

    // Byte classification and limits
    logic             is_nl;
    logic             is_obst;
    logic             is_empty;
    logic             width_ok;
    logic             last_row;
    int unsigned      height_eff;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign is_nl    = (map_byte == NEWLINE_BYTE);
    assign is_obst  = !is_nl && (map_byte == obst_char_reg);
    assign is_empty = !is_nl && (map_byte == empty_char_reg);

    // A height of zero acts as one, and anything above the maximum as the maximum.
    always_comb
    begin
        if (map_height_reg == '0)
            height_eff = 1;
        else if (32'(map_height_reg) > 32'(MAX_HEIGHT))
            height_eff = 32'(MAX_HEIGHT);
        else
            height_eff = 32'(map_height_reg);
    end

    assign last_row = (32'(row_reg) + 32'd1) >= height_eff;
    assign width_ok = (map_width_reg != '0) && (32'(map_width_reg) <= 32'(MAX_WIDTH))
                      && (col_reg == map_width_reg);

    // First stage: classify the byte, update control state and issue the line buffer read.
    always_comb
    begin
        row_obst_next = row_obst_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        err_next      = err_reg;

        s1_next            = '0;
        s1_next.row        = row_reg;
        s1_next.col        = col_reg;
        s1_next.first_row  = (row_reg == '0);
        s1_next.row_obst   = row_obst_reg;
        s1_next.zero_count = 1'b1;
        s1_next.kind       = KIND_BAD_LEN;

        priority if (err_reg)
        begin
            s1_next.kind = (is_nl || is_obst || is_empty) ? KIND_BAD_LEN : KIND_BAD_CHAR;
        end
        else if (is_nl)
        begin
            if (!width_ok)
            begin
                err_next     = 1'b1;
                s1_next.kind = KIND_BAD_LEN;
            end
            else
            begin
                s1_next.kind       = KIND_ROW_END;
                s1_next.zero_count = 1'b0;
                s1_next.done       = last_row;
                col_next           = '0;
                row_obst_next      = '0;
                row_next           = last_row ? '0 : row_reg + RW'(1);
            end
        end
        else if (!is_obst && !is_empty)
        begin
            err_next     = 1'b1;
            s1_next.kind = KIND_BAD_CHAR;
        end
        else if ((col_reg >= map_width_reg) || (32'(col_reg) >= 32'(MAX_WIDTH)))
        begin
            err_next     = 1'b1;
            s1_next.kind = KIND_BAD_LEN;
        end
        else
        begin
            s1_next.kind       = KIND_CELL;
            s1_next.is_cell    = 1'b1;
            s1_next.zero_count = 1'b0;
            s1_next.row_obst   = row_obst_reg + COL_W'(is_obst);
            row_obst_next      = row_obst_reg + COL_W'(is_obst);
            col_next           = col_reg + COL_W'(1);
        end
    end

    assign rd_en   = accept && s1_next.is_cell;
    assign rd_addr = AW'(col_reg);
    assign wr_addr = AW'(s1_reg.col);

    // Second stage: add the count from the row above and close the beat.
    assign s1_sum = SUM_W'(s1_reg.row_obst) + (s1_reg.first_row ? '0 : rd_sum_reg);

    always_comb
    begin
        if (s1_reg.zero_count)
            s1_count = '0;
        else if (s1_reg.is_cell)
            s1_count = s1_sum;
        else
            s1_count = last_sum_reg;
    end

    // Line buffer of previous-row sums: one read and one write per cycle.
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_sum_reg <= prev_sums_reg[rd_addr];
        if (s1_adv && s1_reg.is_cell)
            prev_sums_reg[wr_addr] <= s1_sum;
    end

    // Payload registers of the second stage and the output
    always_ff @(posedge clk)
    begin
        if (accept)
            s1_reg <= s1_next;
        if (s1_adv)
        begin
            out_count_reg <= s1_count;
            out_row_reg   <= s1_reg.row;
            out_col_reg   <= s1_reg.col;
            out_kind_reg  <= s1_reg.kind;
            out_done_reg  <= s1_reg.done;
            if (s1_reg.is_cell)
                last_sum_reg <= s1_sum;
        end
    end

    // Control state, configuration and valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= RST_MAP_WIDTH;
            map_height_reg <= RST_MAP_HEIGHT;
            obst_char_reg  <= RST_OBST_CHAR;
            empty_char_reg <= RST_EMPTY_CHAR;
            row_obst_reg   <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            err_reg        <= 1'b0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_MAP_WIDTH:  map_width_reg  <= cfg_data;
                    CFG_MAP_HEIGHT: map_height_reg <= cfg_data;
                    CFG_OBST_CHAR:  obst_char_reg  <= cfg_data[7:0];
                    CFG_EMPTY_CHAR: empty_char_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end

            if (accept)
            begin
                row_obst_reg <= row_obst_next;
                row_reg      <= row_next;
                col_reg      <= col_next;
                err_reg      <= err_next;
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign rect_count = out_count_reg;
    assign cell_row   = ROW_W'(out_row_reg);
    assign cell_col   = out_col_reg;
    assign kind       = out_kind_reg;
    assign map_done   = out_done_reg;

endmodule

[tb/sv/obstacle_summed_area_checker.sv]
`timescale 1ns / 1ps
// Checker that predicts every result beat of the obstacle summed-area core and compares it.
module obstacle_summed_area_checker #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [7:0]                      map_byte,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [osas_pkg::SUM_W-1:0]      rect_count,
    input  logic [osas_pkg::ROW_W-1:0]      cell_row,
    input  logic [osas_pkg::COL_W-1:0]      cell_col,
    input  osas_pkg::kind_t                 kind,
    input  logic                            map_done,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [osas_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [osas_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatches,
    output int                              awaiting
);
    import osas_pkg::*;

    localparam int REPORT_LIMIT = 40;

    typedef struct packed {
        logic [SUM_W-1:0] count;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        kind_t            kind;
        logic             done;
    } area_beat_t;

    // Own copy of the line buffer, the row and column counters and the registers.
    logic [SUM_W-1:0] row_above_sums [MAX_WIDTH];
    logic [COL_W-1:0] line_obstacles;
    logic [ROW_W-1:0] cur_row;
    logic [COL_W-1:0] cur_col;
    logic             stuck;
    logic [COL_W-1:0] width_reg;
    logic [COL_W-1:0] height_reg;
    logic [7:0]       obst_reg;
    logic [7:0]       empty_reg;

    area_beat_t awaited_beats [$];

    initial
    begin
        mismatches = 0;
        awaiting   = 0;
        foreach (row_above_sums[i])
            row_above_sums[i] = '0;
    end

    // Works out the result beat caused by one map byte and advances the state.
    function automatic area_beat_t integrate_byte(input logic [7:0] b);
        area_beat_t       r;
        logic             is_nl;
        logic             is_obst;
        logic             is_empty;
        logic             last;
        int               rows_eff;
        logic [SUM_W-1:0] above;
        is_nl    = (b == NEWLINE_BYTE);
        is_obst  = !is_nl && (b == obst_reg);
        is_empty = !is_nl && (b == empty_reg);
        r.count  = '0;
        r.row    = cur_row;
        r.col    = cur_col;
        r.done   = 1'b0;
        r.kind   = KIND_CELL;
        if (stuck)
        begin
            r.kind = (is_nl || is_obst || is_empty) ? KIND_BAD_LEN : KIND_BAD_CHAR;
        end
        else if (is_nl)
        begin
            rows_eff = int'(height_reg);
            if (rows_eff == 0)
                rows_eff = 1;
            if (rows_eff > MAX_HEIGHT)
                rows_eff = MAX_HEIGHT;
            if (width_reg == 0 || width_reg > MAX_WIDTH || cur_col != width_reg)
            begin
                stuck  = 1'b1;
                r.kind = KIND_BAD_LEN;
            end
            else
            begin
                // The row total is the sum just stored for the last cell of this row.
                last           = (int'(cur_row) + 1 >= rows_eff);
                r.count        = row_above_sums[cur_col - 1'b1];
                r.kind         = KIND_ROW_END;
                r.done         = last;
                cur_col        = '0;
                line_obstacles = '0;
                cur_row        = last ? '0 : cur_row + 1'b1;
            end
        end
        else if (!is_obst && !is_empty)
        begin
            stuck  = 1'b1;
            r.kind = KIND_BAD_CHAR;
        end
        else if (cur_col >= width_reg || cur_col >= MAX_WIDTH)
        begin
            stuck  = 1'b1;
            r.kind = KIND_BAD_LEN;
        end
        else
        begin
            above = (cur_row == 0) ? '0 : row_above_sums[cur_col];
            if (is_obst)
                line_obstacles = line_obstacles + 1'b1;
            r.count                 = SUM_W'(line_obstacles) + above;
            row_above_sums[cur_col] = r.count;
            cur_col                 = cur_col + 1'b1;
        end
        return r;
    endfunction

    task automatic count_failure(input string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t ns: %s", $time, what);
        if (mismatches == REPORT_LIMIT)
            $display("Further mismatches are counted but not reported.");
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got)
            count_failure($sformatf("%s expected %0d, got %0d", field, want, got));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        area_beat_t want;
        if (!rst_n)
        begin
            awaited_beats.delete();
            line_obstacles = '0;
            cur_row        = '0;
            cur_col        = '0;
            stuck          = 1'b0;
            width_reg      = RST_MAP_WIDTH;
            height_reg     = RST_MAP_HEIGHT;
            obst_reg       = RST_OBST_CHAR;
            empty_reg      = RST_EMPTY_CHAR;
            awaiting       = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_beats.size() == 0)
                begin
                    count_failure($sformatf({"result beat with nothing awaited: rect_count %0d, ",
                        "cell_row %0d, cell_col %0d, kind %0d, map_done %0d"},
                        rect_count, cell_row, cell_col, kind, map_done));
                end
                else
                begin
                    want = awaited_beats.pop_front();
                    check_field("rect_count", int'(want.count), int'(rect_count));
                    check_field("cell_row", int'(want.row), int'(cell_row));
                    check_field("cell_col", int'(want.col), int'(cell_col));
                    check_field("kind", int'(want.kind), int'(kind));
                    check_field("map_done", int'(want.done), int'(map_done));
                end
            end
            // A byte taken at the same edge as a register write still sees the old setting.
            if (in_valid && !in_stall)
                awaited_beats.push_back(integrate_byte(map_byte));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MAP_WIDTH:  width_reg  = cfg_data;
                    CFG_MAP_HEIGHT: height_reg = cfg_data;
                    CFG_OBST_CHAR:  obst_reg   = cfg_data[7:0];
                    CFG_EMPTY_CHAR: empty_reg  = cfg_data[7:0];
                    default: ;
                endcase
            end
            awaiting = awaited_beats.size();
        end
    end

endmodule

[tb/sv/obstacle_summed_area_stream_core_test.sv]
`timescale 1ns / 1ps
// Testbench top of the obstacle summed-area core: stimulus, handshakes and the verdict.
module obstacle_summed_area_stream_core_test;
    import osas_pkg::*;

    localparam int MAX_WIDTH     = 1024;
    localparam int MAX_HEIGHT    = 1024;
    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 4;
    localparam int RANDOM_BYTES  = 1000;
    localparam int WIDE_ROW_MAX  = 64;
    localparam int HOLD_CYCLES   = 300;
    localparam int TAIL_BYTES    = 60;
    localparam int SETTLE_CYCLES = 10;
    localparam int RUN_LIMIT_NS  = 2_000_000;

    // The fault that ends the run; the error is sticky and reset comes only once.
    typedef enum int {
        CLOSE_BAD_CHAR,
        CLOSE_TOO_LONG,
        CLOSE_TOO_SHORT,
        CLOSE_WIDTH_RANGE
    } closing_t;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    logic [7:0]            map_byte   = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic [SUM_W-1:0]      rect_count;
    logic [ROW_W-1:0]      cell_row;
    logic [COL_W-1:0]      cell_col;
    kind_t                 kind;
    logic                  map_done;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    int                    mismatches;
    int                    awaiting;

    // The map format currently programmed, as the stimulus sees it.
    int         fmt_width  = 1;
    int         fmt_height = 1;
    logic [7:0] fmt_obst   = RST_OBST_CHAR;
    logic [7:0] fmt_empty  = RST_EMPTY_CHAR;

    // Idling controls shared between the sender and the receiver process.
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_left    = 0;
    bit hold_request = 1'b0;

    int       bytes_sent   = 0;
    int       maps_sent    = 0;
    int       formats_used = 0;
    closing_t closing;
    string    fault_note;

    obstacle_summed_area_stream_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) uut (.*);

    obstacle_summed_area_checker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) checker_i (.*);

    always #(HALF_PERIOD) clk = ~clk;

    // Receiver. A hold-off request from the stimulus takes priority and keeps the output
    // stalled for a long stretch; otherwise the stall is drawn at random each cycle.
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    // The run is cut short if the block hangs.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("FAIL");
        $finish;
    end

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    // Decides whether the sender leaves the next cycle empty.
    function automatic bit tx_gap();
        return ($urandom_range(0, 99) < tx_idle_pct);
    endfunction

    // Offers one map byte and returns at the falling edge after the beat was taken.
    // Valid stays high on return, so the next call carries straight on unless it draws a gap.
    task automatic send_byte(input logic [7:0] b);
        while (tx_gap())
        begin
            in_valid <= 1'b0;
            map_byte <= 8'($urandom_range(0, 255));
            @(negedge clk);
        end
        in_valid <= 1'b1;
        map_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= CFG_DATA_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    // Registers change only while the block is idle: the sender stops and waits until
    // every awaited result beat has come out. Every result beat follows its byte, so
    // nothing is left in flight once the checker has nothing outstanding.
    task automatic set_map_format(input int width, input int height,
                                  input logic [7:0] obst, input logic [7:0] empty);
        in_valid <= 1'b0;
        while (awaiting != 0)
            @(negedge clk);
        write_register(CFG_MAP_WIDTH, width);
        write_register(CFG_MAP_HEIGHT, height);
        write_register(CFG_OBST_CHAR, obst);
        write_register(CFG_EMPTY_CHAR, empty);
        cfg_valid  <= 1'b0;
        fmt_width  = width;
        fmt_height = height;
        fmt_obst   = obst;
        fmt_empty  = empty;
        formats_used++;
    endtask

    // A character code equal to the newline can never stand for a cell, since the
    // newline always ends the row; the other code is used instead.
    function automatic logic [7:0] pick_cell(input int obst_pct);
        if (fmt_obst == NEWLINE_BYTE)
            return fmt_empty;
        if (fmt_empty == NEWLINE_BYTE)
            return fmt_obst;
        return ($urandom_range(0, 99) < obst_pct) ? fmt_obst : fmt_empty;
    endfunction

    task automatic send_row(input int cells, input int obst_pct);
        repeat (cells)
            send_byte(pick_cell(obst_pct));
        send_byte(NEWLINE_BYTE);
    endtask

    // A whole map ends on a row boundary with row zero next, so a later and wider format
    // never reads a line buffer entry that no row has written.
    task automatic send_map(input int obst_pct);
        int rows;
        rows = fmt_height;
        if (rows == 0)
            rows = 1;
        if (rows > MAX_HEIGHT)
            rows = MAX_HEIGHT;
        repeat (rows)
            send_row(fmt_width, obst_pct);
        maps_sent++;
    endtask

    // Mostly narrow maps to keep the run short, with the odd wider one. Codes are drawn
    // over the whole byte range, sometimes equal and sometimes equal to the newline.
    task automatic pick_random_format();
        int         width;
        logic [7:0] obst;
        logic [7:0] empty;
        width = ($urandom_range(0, 7) == 0) ? $urandom_range(13, WIDE_ROW_MAX)
                                            : $urandom_range(1, 12);
        obst  = 8'($urandom_range(0, 255));
        empty = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 7) == 0)
            empty = obst;
        if (obst == NEWLINE_BYTE && empty == NEWLINE_BYTE)
            empty = RST_EMPTY_CHAR;
        set_map_format(width, $urandom_range(0, 6), obst, empty);
    endtask

    // Ends the well-formed part of the run with one of the faults, chosen at random.
    task automatic break_map();
        logic [7:0] junk;
        closing = closing_t'($urandom_range(0, 3));
        if (closing == CLOSE_WIDTH_RANGE)
        begin
            // Width zero fails on the first cell (or the newline if none); one above the maximum on the newline.
            fault_note = "width out of range";
            set_map_format(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(MAX_WIDTH + 1, 2047),
                           2, RST_OBST_CHAR, RST_EMPTY_CHAR);
            repeat ($urandom_range(0, 3))
                send_byte(pick_cell(50));
            send_byte(NEWLINE_BYTE);
        end
        else
        begin
            // One sound row first, so that the fault usually lands below row zero.
            pick_random_format();
            send_row(fmt_width, 50);
            case (closing)
                CLOSE_BAD_CHAR:
                begin
                    fault_note = "bad character";
                    repeat ($urandom_range(0, fmt_width - 1))
                        send_byte(pick_cell(50));
                    do
                        junk = 8'($urandom_range(0, 255));
                    while (junk == NEWLINE_BYTE || junk == fmt_obst || junk == fmt_empty);
                    send_byte(junk);
                end
                CLOSE_TOO_LONG:
                begin
                    fault_note = "row too long";
                    send_row(fmt_width + 1, 50);
                end
                default:
                begin
                    fault_note = "row too short";
                    send_row($urandom_range(0, fmt_width - 1), 50);
                end
            endcase
        end
    endtask

    initial
    begin
        int random_start;
        int progress;
        bit hold_done;
        hold_done = 1'b0;

        repeat (RESET_CYCLES)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed beats. Two one-cell maps with the reset format, so that each newline
        // both ends the row and marks the end of the map.
        set_idling(16, 85);
        send_byte(RST_OBST_CHAR);
        send_byte(NEWLINE_BYTE);
        send_byte(RST_EMPTY_CHAR);
        send_byte(NEWLINE_BYTE);
        // Codes at both ends of the byte range, with a second row that adds the first.
        set_map_format(3, 2, 8'hFF, 8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(NEWLINE_BYTE);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(NEWLINE_BYTE);
        maps_sent += 3;
        // One code for both kinds of cell counts as an obstacle; a height of zero acts
        // as a single row.
        set_map_format(2, 0, 8'h23, 8'h23);
        send_map(50);
        // An obstacle code equal to the newline: the newline still ends the row.
        set_map_format(2, 1, NEWLINE_BYTE, RST_EMPTY_CHAR);
        send_map(50);

        // Random well-formed maps in three stages of idling: first a slow receiver, then
        // a slow sender, then none. The last stage opens with a long receiver hold-off
        // while a full map is offered, so the block fills and stalls its input.
        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES)
        begin
            progress = (bytes_sent - random_start) * 3 / RANDOM_BYTES;
            if (progress == 0)
                set_idling(16, 85);
            else if (progress == 1)
                set_idling(85, 16);
            else
                set_idling(0, 0);
            if (progress == 2 && !hold_done)
            begin
                set_map_format(16, 3, RST_OBST_CHAR, RST_EMPTY_CHAR);
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            else
            begin
                pick_random_format();
            end
            repeat ($urandom_range(1, 3))
                send_map($urandom_range(0, 100));
        end

        // The closing fault, then a tail of mixed bytes while the error is held.
        break_map();
        repeat (TAIL_BYTES)
        begin
            case ($urandom_range(0, 3))
                0:       send_byte(NEWLINE_BYTE);
                1:       send_byte(fmt_obst);
                2:       send_byte(fmt_empty);
                default: send_byte(8'($urandom_range(0, 255)));
            endcase
        end
        in_valid <= 1'b0;

        // Drain, then give any stray beat time to show up before the verdict.
        while (awaiting != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);

        $display("Run covered %0d map bytes in %0d formats and %0d whole maps,",
                 bytes_sent, formats_used, maps_sent);
        $display("rows of up to %0d cells, then a %s fault held over %0d more bytes.",
                 WIDE_ROW_MAX, fault_note, TAIL_BYTES);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
src/osas_pkg.sv
src/obstacle_summed_area_stream_core.sv
tb/sv/obstacle_summed_area_checker.sv
tb/sv/obstacle_summed_area_stream_core_test.sv
